[rtl/assert_macros.svh]
// Assertion macros shared by the voltmeter RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AVM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AVM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/avm_pkg.sv]
// Shared widths, scaling constants and result types of the averaging voltmeter.
package avm_pkg;

    localparam int unsigned SAMPLE_W        = 12;
    localparam int unsigned MV_W            = 12;
    localparam int unsigned FULL_SCALE_CODE = (2 ** SAMPLE_W) - 1;
    localparam int unsigned FULL_SCALE_MV   = 3300;
    localparam int unsigned BAR_CELLS       = 16;

    // Width of avg * 3300, which stays below 2^24.
    localparam int unsigned PROD_W = 24;

    // floor(x / 4095) for x < 2^24 as (x * ceil(2^36 / 4095)) >> 36.
    localparam int unsigned MV_SHIFT   = 36;
    localparam int unsigned MV_RECIP_W = 25;
    localparam logic [MV_RECIP_W-1:0] MV_RECIP =
        MV_RECIP_W'(((64'd1 << MV_SHIFT) + FULL_SCALE_CODE - 1) / FULL_SCALE_CODE);

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 48;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_code;
        logic [MV_W-1:0]     millivolts;
    } mv_item_t;

    // Listed from the top bit down, so average_code sits in the lowest bits.
    typedef struct packed {
        logic [4:0]          bar_cells;
        logic [3:0]          digit_ones;
        logic [3:0]          digit_tens;
        logic [3:0]          digit_hundreds;
        logic [1:0]          digit_thousands;
        logic [MV_W-1:0]     millivolts;
        logic [SAMPLE_W-1:0] average_code;
    } res_t;

endpackage

[rtl/avm_accum.sv]
// Block accumulator and constant-divisor averaging stage.
`include "assert_macros.svh"

module avm_accum import avm_pkg::*; #(
    parameter int unsigned SAMPLES_AVERAGED = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                s_tvalid,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                avg_valid,
    output logic [SAMPLE_W-1:0] avg_code
);

    localparam int unsigned CNT_W       = $clog2(SAMPLES_AVERAGED);
    localparam int unsigned SUM_W       = SAMPLE_W + CNT_W;
    localparam int unsigned RECIP_SHIFT = SUM_W + CNT_W + 1;
    localparam int unsigned RECIP_W     = RECIP_SHIFT - CNT_W + 2;
    localparam int unsigned AVG_PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_AVERAGED - 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUM_W-1:0]      sum_in;
    logic                  blk_valid_reg;
    logic [SUM_W-1:0]      blk_sum_reg;
    logic                  avg_valid_reg;
    logic [SAMPLE_W-1:0]   avg_reg;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic                  take;
    logic                  last;

    assign take   = en && s_tvalid;
    assign last   = (count_reg == LAST_COUNT);
    assign sum_in = sum_reg + SUM_W'(sample);

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (take) begin
            if (last) begin
                count_next = '0;
                sum_next   = '0;
            end else begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_in;
            end
        end
    end

    // Exact floor division of the block sum by the block length.
    assign avg_prod = {{RECIP_W{1'b0}}, blk_sum_reg} * {{SUM_W{1'b0}}, RECIP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sum_reg       <= '0;
            blk_valid_reg <= 1'b0;
            avg_valid_reg <= 1'b0;
        end else if (en) begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            blk_valid_reg <= take && last;
            avg_valid_reg <= blk_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            blk_sum_reg <= sum_in;
            avg_reg     <= avg_prod[RECIP_SHIFT +: SAMPLE_W];
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_code  = avg_reg;

    `AVM_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg <= LAST_COUNT, "block count overran")
    `AVM_ASSERT_NEXT(a_block_close, aclk, aresetn, take && last, (count_reg == '0) && (sum_reg == '0) && blk_valid_reg, "block end did not clear the sum")

endmodule

[rtl/avm_scale.sv]
// Two-stage scaling of the average code to millivolts.
`include "assert_macros.svh"

module avm_scale import avm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                avg_valid,
    input  logic [SAMPLE_W-1:0] avg_code,
    output logic                mv_valid,
    output mv_item_t            mv_item
);

    localparam int unsigned MV_PROD_W = PROD_W + MV_RECIP_W;

    logic                 prod_valid_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SAMPLE_W-1:0]  prod_avg_reg;
    logic                 mv_valid_reg;
    mv_item_t             mv_item_reg;
    logic [MV_PROD_W-1:0] mv_prod;

    // Divide by 4095 through the reciprocal; exact for every product below 2^24.
    assign mv_prod = {{MV_RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, MV_RECIP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            mv_valid_reg   <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= avg_valid;
            mv_valid_reg   <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg                 <= PROD_W'(avg_code) * PROD_W'(FULL_SCALE_MV);
            prod_avg_reg             <= avg_code;
            mv_item_reg.average_code <= prod_avg_reg;
            mv_item_reg.millivolts   <= mv_prod[MV_SHIFT +: MV_W];
        end
    end

    assign mv_valid = mv_valid_reg;
    assign mv_item  = mv_item_reg;

    `AVM_ASSERT_NOW(a_mv_full_scale, aclk, aresetn, mv_valid_reg, mv_item_reg.millivolts <= MV_W'(FULL_SCALE_MV), "millivolts above full scale")

endmodule

[rtl/avm_digits.sv]
// Decimal digit split and bar length of the millivolt value in stages A, B and C.
`include "assert_macros.svh"

module avm_digits import avm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     mv_valid,
    input  mv_item_t mv_item,
    output logic     res_valid,
    output res_t     res
);

    typedef struct packed {
        mv_item_t   item;
        logic [1:0] thousands;
        logic [4:0] bar;
        logic [9:0] rem;
    } stage_a_t;

    typedef struct packed {
        mv_item_t   item;
        logic [1:0] thousands;
        logic [4:0] bar;
        logic [3:0] hundreds;
        logic [6:0] rem;
    } stage_b_t;

    // Digit of value in base weight, for value below ten times weight.
    function automatic logic [3:0] digit_of(input logic [9:0] value,
                                            input logic [9:0] weight);
        logic [8:0] ge;
        for (int k = 1; k <= 9; k++) begin
            ge[k-1] = (value >= 10'(weight * k));
        end
        return 4'($countones(ge));
    endfunction

    logic             a_valid_reg, b_valid_reg, c_valid_reg;
    stage_a_t         a_reg, a_next;
    stage_b_t         b_reg, b_next;
    res_t             c_reg, c_next;
    logic [2:0]       th_ge;
    logic [BAR_CELLS-1:0] bar_ge;

    // Stage A: volts digit and the bar length from threshold compares.
    always_comb begin
        th_ge = {mv_item.millivolts >= MV_W'(3000),
                 mv_item.millivolts >= MV_W'(2000),
                 mv_item.millivolts >= MV_W'(1000)};
        for (int k = 1; k <= BAR_CELLS; k++) begin
            bar_ge[k-1] = mv_item.millivolts >=
                          MV_W'((FULL_SCALE_MV * k + BAR_CELLS - 1) / BAR_CELLS);
        end
        a_next.item      = mv_item;
        a_next.thousands = 2'($countones(th_ge));
        a_next.bar       = 5'($countones(bar_ge));
        a_next.rem       = 10'(mv_item.millivolts -
                               MV_W'(MV_W'(a_next.thousands) * MV_W'(1000)));
    end

    // Stage B: hundreds digit.
    always_comb begin
        b_next.item      = a_reg.item;
        b_next.thousands = a_reg.thousands;
        b_next.bar       = a_reg.bar;
        b_next.hundreds  = digit_of(a_reg.rem, 10'd100);
        b_next.rem       = 7'(a_reg.rem - 10'(10'(b_next.hundreds) * 10'd100));
    end

    // Stage C: tens and ones digits.
    always_comb begin
        c_next.average_code    = b_reg.item.average_code;
        c_next.millivolts      = b_reg.item.millivolts;
        c_next.digit_thousands = b_reg.thousands;
        c_next.digit_hundreds  = b_reg.hundreds;
        c_next.bar_cells       = b_reg.bar;
        c_next.digit_tens      = digit_of({3'b000, b_reg.rem}, 10'd10);
        c_next.digit_ones      = 4'(b_reg.rem - 7'(7'(c_next.digit_tens) * 7'd10));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= mv_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign res_valid = c_valid_reg;
    assign res       = c_reg;

    `AVM_ASSERT_NOW(a_rem_range, aclk, aresetn, a_valid_reg, a_reg.rem < 10'd1000, "remainder after volts digit out of range")
    `AVM_ASSERT_NOW(a_digit_range, aclk, aresetn, c_valid_reg, (c_reg.digit_hundreds <= 4'd9) && (c_reg.digit_tens <= 4'd9) && (c_reg.digit_ones <= 4'd9), "decimal digit above nine")

endmodule

[rtl/avm_out_reg.sv]
// Output register with a one-entry skid stage that stalls the pipeline.
`include "assert_macros.svh"

module avm_out_reg import avm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic res_valid,
    input  res_t res,
    output logic en,
    input  logic m_tready,
    output logic m_tvalid,
    output res_t m_res
);

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;
    logic out_free;

    // The pipeline moves only while the skid stage is empty.
    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (out_free) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    `AVM_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid entry held with empty output")
    `AVM_ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && m_tready, out_valid_reg && !skid_valid_reg, "skid entry not moved to output")

endmodule

[rtl/adc_average_voltmeter_digits.sv]
// A block result passes the block sum, average, product, millivolt, A, B, C and output registers.
// Throughput: one sample transfer per cycle unless stalled; the seven stages move as one unit.
// s_tready falls only when the output register and its skid entry both hold results.
// Reset (aresetn low at a clock edge) clears the sample count, the running sum and all valid bits.
// The payload registers are not reset; no result is presented until a block completes.
module adc_average_voltmeter_digits import avm_pkg::*; #(
    parameter int unsigned SAMPLES_AVERAGED = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [11:0] sample; upper bits ignored
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [11:0] average_code, [23:12] millivolts, [25:24] digit_thousands,
    // [29:26] digit_hundreds, [33:30] digit_tens, [37:34] digit_ones,
    // [42:38] bar_cells, [47:43] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Pipeline advance. It is a registered flag, so there is no combinational
    // path from m_tready back to s_tready.
    logic                en;
    logic                avg_valid;
    logic [SAMPLE_W-1:0] avg_code;
    logic                mv_valid;
    mv_item_t            mv_item;
    logic                res_valid;
    res_t                res;
    res_t                m_res;

    // s_tready is the pipeline advance, so a sample transfers whenever s_tvalid is high while it advances.
    assign s_tready = en;

    // Stage 1 accumulates the block; stage 2 holds the block average.
    avm_accum #(
        .SAMPLES_AVERAGED (SAMPLES_AVERAGED)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_tvalid  (s_tvalid),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .avg_valid (avg_valid),
        .avg_code  (avg_code)
    );

    // Stages 3 and 4 turn the average code into millivolts.
    avm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .avg_valid (avg_valid),
        .avg_code  (avg_code),
        .mv_valid  (mv_valid),
        .mv_item   (mv_item)
    );

    // Stages 5 to 7 split the millivolts into decimal digits and a bar length.
    avm_digits u_digits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .mv_valid  (mv_valid),
        .mv_item   (mv_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // The output register holds the result until its transfer; the skid entry
    // catches the one result that is still moving when the output stalls.
    avm_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .en        (en),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res)
    );

    assign m_tdata = M_TDATA_W'(m_res);

endmodule

[test/adc_average_voltmeter_digits_tb.sv]
// Self-checking testbench for the block-averaging ADC voltmeter with digit and bar outputs.
module adc_average_voltmeter_digits_tb import avm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BLOCK_LEN        = 16;
    localparam int unsigned RANDOM_BLOCKS    = 100;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES    = 30;
    localparam int unsigned CYCLE_LIMIT      = 200000;

    // The scoreboard keeps its own copy of the accumulator state. Each accepted
    // sample transfer advances it; the sixteenth sample of a block produces one
    // expected result, and each result transfer is checked against the oldest one.
    class avg_scoreboard;
        int unsigned     samples_in_block;
        logic [15:0]     block_sum;
        res_t            pending[$];
        int unsigned     mismatches;
        int unsigned     results_checked;
        int unsigned     samples_seen;

        function new();
            samples_in_block = 0;
            block_sum        = '0;
            mismatches       = 0;
            results_checked  = 0;
            samples_seen     = 0;
        endfunction

        task report(input string what, input int unsigned got, input int unsigned want);
            mismatches++;
            $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task note_sample(input logic [S_TDATA_W-1:0] word);
            res_t        exp_res;
            int unsigned avg;
            int unsigned mv;
            samples_seen++;
            // Bits above the sample width are not part of the conversion.
            block_sum = block_sum + 16'(word[SAMPLE_W-1:0]);
            samples_in_block++;
            if (samples_in_block == BLOCK_LEN) begin
                avg = block_sum / BLOCK_LEN;
                mv  = (avg * FULL_SCALE_MV) / FULL_SCALE_CODE;
                exp_res.average_code    = SAMPLE_W'(avg);
                exp_res.millivolts      = MV_W'(mv);
                exp_res.digit_thousands = 2'(mv / 1000);
                exp_res.digit_hundreds  = 4'((mv / 100) % 10);
                exp_res.digit_tens      = 4'((mv / 10) % 10);
                exp_res.digit_ones      = 4'(mv % 10);
                exp_res.bar_cells       = 5'((mv * BAR_CELLS) / FULL_SCALE_MV);
                pending.push_back(exp_res);
                samples_in_block = 0;
                block_sum        = '0;
            end
        endtask

        task check_result(input logic [M_TDATA_W-1:0] word);
            res_t got_res;
            res_t exp_res;
            got_res = word[$bits(res_t)-1:0];
            if (pending.size() == 0) begin
                report("unexpected result, average_code", got_res.average_code, 0);
            end else begin
                exp_res = pending.pop_front();
                results_checked++;
                if (got_res.average_code !== exp_res.average_code)
                    report("average_code", got_res.average_code, exp_res.average_code);
                if (got_res.millivolts !== exp_res.millivolts)
                    report("millivolts", got_res.millivolts, exp_res.millivolts);
                if (got_res.digit_thousands !== exp_res.digit_thousands)
                    report("digit_thousands", got_res.digit_thousands,
                           exp_res.digit_thousands);
                if (got_res.digit_hundreds !== exp_res.digit_hundreds)
                    report("digit_hundreds", got_res.digit_hundreds, exp_res.digit_hundreds);
                if (got_res.digit_tens !== exp_res.digit_tens)
                    report("digit_tens", got_res.digit_tens, exp_res.digit_tens);
                if (got_res.digit_ones !== exp_res.digit_ones)
                    report("digit_ones", got_res.digit_ones, exp_res.digit_ones);
                if (got_res.bar_cells !== exp_res.bar_cells)
                    report("bar_cells", got_res.bar_cells, exp_res.bar_cells);
            end
            // The padding above the last field must read as zero.
            if (word[M_TDATA_W-1:$bits(res_t)] !== '0)
                report("padding bits", word[M_TDATA_W-1:$bits(res_t)], 0);
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    avg_scoreboard sb = new();

    // Idling controls shared by the sender and the receiver processes.
    bit          sender_quiet   = 1'b0;
    bit          receiver_quiet = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    adc_average_voltmeter_digits u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // Both channels are observed at the rising edge, where the testbench's own
    // signals have been stable since the falling edge and the block's outputs
    // still hold their values from before the edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (s_tvalid && s_tready)
                    sb.note_sample(s_tdata);
                if (m_tvalid && m_tready)
                    sb.check_result(m_tdata);
            end
        end
    end

    // Receiver. A long hold requested by the stimulus takes priority; otherwise
    // the ready line drops in random bursts unless the receiver has been told
    // to run without idling.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!receiver_quiet && aresetn && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending.size());
        $display("status: fail");
        $finish;
    end

    // Offers one sample; called at a falling edge and returns at a falling edge.
    // A random gap with tvalid low may come first. tvalid stays high from one
    // transfer to the next when there is no gap.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                               input logic [S_TDATA_W-SAMPLE_W-1:0] upper);
        int unsigned gap;
        if (!sender_quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {upper, sample};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering samples until every expected result has been transferred.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One block of samples. Most blocks sit around a level so that the average
    // lands where chosen; some are pure noise over the whole code range.
    task automatic send_random_block();
        int kind;
        int level;
        int value;
        kind = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0:       level = 0;
            1:       level = FULL_SCALE_CODE;
            2:       level = $urandom_range(0, 3);
            3:       level = FULL_SCALE_CODE - $urandom_range(0, 3);
            default: level = $urandom_range(0, FULL_SCALE_CODE);
        endcase
        for (int i = 0; i < BLOCK_LEN; i++) begin
            case (kind)
                0:       value = $urandom_range(0, FULL_SCALE_CODE);
                1:       value = level;
                default: value = level + $urandom_range(0, 64) - 32;
            endcase
            if (value < 0) value = 0;
            if (value > FULL_SCALE_CODE) value = FULL_SCALE_CODE;
            send_sample(SAMPLE_W'(value), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Full-scale block with every upper bit set: the upper bits must be
        // ignored and the outputs reach 3300 mV, digits 3-3-0-0 and a full bar.
        for (int i = 0; i < BLOCK_LEN; i++)
            send_sample({SAMPLE_W{1'b1}}, 4'hF);
        // Zero samples under random upper bits: the bottom of every output.
        for (int i = 0; i < BLOCK_LEN; i++)
            send_sample('0, 4'($urandom_range(0, 15)));
        drain_results();

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            // A long receiver hold while the sender streams without gaps fills
            // the pipeline and the skid entry, so s_tready must fall.
            if (blk == 30) begin
                sender_quiet = 1'b1;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (blk == 45)
                sender_quiet = 1'b0;
            if (blk == 60)
                drain_results();
            // The closing stretch runs at full rate on both sides.
            if (blk == 85) begin
                sender_quiet   = 1'b1;
                receiver_quiet = 1'b1;
            end
            send_random_block();
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d sample transfers and %0d block results, including a long",
                 sb.samples_seen, sb.results_checked);
        $display("output hold with back-pressure, full-scale and zero blocks, and masked upper bits");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
